/* design/ebe_pkg.sv */
`timescale 1ns / 1ps
package ebe_pkg;

	localparam int unsigned MAX_RUN = 4;
	localparam int unsigned RUN_IDX_W = $clog2(MAX_RUN);

	localparam logic [7:0] ESCAPE_CHAR_RST = 8'd35;
	localparam logic [7:0] RIGHT_DELIM_RST = 8'd0;
	localparam logic       HTTP_MODE_RST   = 1'b0;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CTRL_MAX = 8'h1F;
	localparam logic [7:0] DEL_MIN  = 8'h7F;

	typedef enum logic [1:0] {
		CFG_ESCAPE_CHAR = 2'd0,
		CFG_RIGHT_DELIM = 2'd1,
		CFG_HTTP_MODE   = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] d;
		if (nib < 4'd10) begin
			d = 8'h30 + {4'h0, nib};
		end else begin
			d = 8'h37 + {4'h0, nib};
		end
		return d;
	endfunction

	function automatic logic [7:0] word_lower(input logic [1:0] pos);
		logic [7:0] d;
		case (pos)
			2'd0: d = 8'h68;
			2'd1: d = 8'h74;
			2'd2: d = 8'h74;
			default: d = 8'h70;
		endcase
		return d;
	endfunction

	function automatic logic [7:0] word_upper(input logic [1:0] pos);
		logic [7:0] d;
		case (pos)
			2'd0: d = 8'h48;
			2'd1: d = 8'h54;
			2'd2: d = 8'h54;
			default: d = 8'h50;
		endcase
		return d;
	endfunction

endpackage

/* design/byte_escape_encoder.sv */
`timescale 1ns / 1ps
// an accepted item is registered in the input register, and then its run of
// escaped bytes in the output byte registers; one output byte per cycle while
// out_stall is low; an item gives 1, 2 or 4 output bytes, sent in index order
// an input register lets the next item wait while the current run drains
// reset: registers to defaults, match position zero, space flag set, no items held
module byte_escape_encoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ebe_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ebe_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);
	import ebe_pkg::*;

	logic [7:0] escape_char_q;
	logic [7:0] right_delim_q;
	logic       http_mode_q;
	logic [1:0] match_pos_q;
	logic       prev_space_q;

	logic       valid_s1;
	in_item_t   item_s1;

	logic                 res_valid_q;
	logic [7:0]           res_bytes_q [MAX_RUN];
	logic [RUN_IDX_W-1:0] res_last_q;
	logic [RUN_IDX_W-1:0] res_idx_q;

	logic in_acc, res_take, res_done, move;

	logic [7:0]           n_bytes [MAX_RUN];
	logic [RUN_IDX_W-1:0] n_last;
	logic [1:0]           n_match;
	logic                 n_space;

	assign cfg_ready = 1'b1;

	assign res_take = res_valid_q && !out_stall;
	assign res_done = res_take && (res_idx_q == res_last_q);
	assign move     = valid_s1 && (!res_valid_q || res_done);
	assign in_stall = valid_s1 && !move;
	assign in_acc   = in_valid && !in_stall;

	assign out_valid            = res_valid_q;
	assign out_data.out_byte    = res_bytes_q[res_idx_q];
	assign out_data.last_of_run = (res_idx_q == res_last_q);

	// escape logic on the held item
	always_comb begin
		logic [7:0] c;
		logic [1:0] pos;
		logic       sp;
		logic [2:0] nxt;
		c   = item_s1.in_byte;
		pos = item_s1.start_of_string ? 2'd0 : match_pos_q;
		sp  = item_s1.start_of_string ? 1'b1 : prev_space_q;
		nxt = 3'd0;
		for (int i = 0; i < MAX_RUN; i++) begin
			n_bytes[i] = c;
		end
		n_last  = RUN_IDX_W'(0);
		n_match = pos;
		n_space = sp;
		if (http_mode_q) begin
			if (c == word_lower(2'd0) || c == word_upper(2'd0)) begin
				nxt = 3'd1;
			end else if (c == word_lower(pos) || c == word_upper(pos)) begin
				nxt = {1'b0, pos} + 3'd1;
			end else begin
				nxt = 3'd0;
			end
		end
		if (http_mode_q && nxt == 3'd4) begin
			n_match    = 2'd0;
			n_bytes[0] = escape_char_q;
			n_bytes[1] = c;
			n_last     = RUN_IDX_W'(1);
		end else begin
			if (http_mode_q) begin
				n_match = nxt[1:0];
			end
			if (sp && c == CH_SPACE) begin
				n_bytes[0] = escape_char_q;
				n_bytes[1] = CH_SPACE;
				n_last     = RUN_IDX_W'(1);
			end else begin
				n_space    = (c == CH_SPACE);
				n_bytes[0] = escape_char_q;
				n_last     = RUN_IDX_W'(1);
				case (c)
					8'h00: n_bytes[1] = 8'h30;
					8'h08: n_bytes[1] = 8'h62;
					8'h0C: n_bytes[1] = 8'h66;
					8'h0A: n_bytes[1] = 8'h6E;
					8'h0D: n_bytes[1] = 8'h72;
					8'h09: n_bytes[1] = 8'h74;
					8'h0B: n_bytes[1] = 8'h76;
					default: begin
						if (c inside {[8'h00:CTRL_MAX], [DEL_MIN:8'hFF]}) begin
							n_bytes[1] = CH_X;
							n_bytes[2] = hex_digit(c[7:4]);
							n_bytes[3] = hex_digit(c[3:0]);
							n_last     = RUN_IDX_W'(3);
						end else if (c == escape_char_q || c == right_delim_q) begin
							n_bytes[1] = c;
						end else begin
							n_bytes[0] = c;
							n_last     = RUN_IDX_W'(0);
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_char_q <= ESCAPE_CHAR_RST;
			right_delim_q <= RIGHT_DELIM_RST;
			http_mode_q   <= HTTP_MODE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_ESCAPE_CHAR: escape_char_q <= cfg_data;
				CFG_RIGHT_DELIM: right_delim_q <= cfg_data;
				CFG_HTTP_MODE:   http_mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_q  <= 1'b0;
			res_idx_q    <= '0;
			res_last_q   <= '0;
			match_pos_q  <= 2'd0;
			prev_space_q <= 1'b1;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				res_valid_q  <= 1'b1;
				res_idx_q    <= '0;
				res_last_q   <= n_last;
				match_pos_q  <= n_match;
				prev_space_q <= n_space;
			end else if (res_done) begin
				res_valid_q <= 1'b0;
			end else if (res_take) begin
				res_idx_q <= res_idx_q + RUN_IDX_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= in_data;
		end
		if (move) begin
			for (int i = 0; i < MAX_RUN; i++) begin
				res_bytes_q[i] <= n_bytes[i];
			end
		end
	end

endmodule
